[rtl/particle_pool_update_defines.svh]
// Assertion macros shared by the checker.
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ppu_pkg.sv]
`default_nettype none

package ppu_pkg;

	localparam int unsigned LANE_W = 16;
	localparam int unsigned VEC_W  = 3 * LANE_W;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned ACC_W  = 17;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EMIT_POS  = 3'd0,
		CFG_INIT_VEL  = 3'd1,
		CFG_ACCEL     = 3'd2,
		CFG_LIFETIME  = 3'd3,
		CFG_PERIOD    = 3'd4,
		CFG_MAX_LIVE  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [VEC_W-1:0]  pos;
		logic [VEC_W-1:0]  vel;
		logic [VEC_W-1:0]  acc;
		logic [LANE_W-1:0] life;
	} entry_t;

	typedef struct packed {
		logic                start;
		logic [ACC_W-1:0]    dividend;
		logic [LANE_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [ACC_W-1:0]    quo;
		logic [LANE_W-1:0]   rem;
	} div_rsp_t;

	function automatic logic [LANE_W-1:0] sat16(input logic signed [25:0] v);
		logic [LANE_W-1:0] r;
		if (v > 26'sd32767)
			r = 16'h7FFF;
		else if (v < -26'sd32768)
			r = 16'h8000;
		else
			r = v[LANE_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/ppu_pool_mem.sv]
`default_nettype none

module ppu_pool_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire ppu_pkg::entry_t   wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output ppu_pkg::entry_t        rdata
);

	ppu_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/ppu_integ.sv]
`default_nettype none

// Stage 1 registers the six v*dt and a*dt products; add and saturate follow.
module ppu_integ (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [ppu_pkg::VEC_W-1:0]     pos,
	input  wire logic [ppu_pkg::VEC_W-1:0]     vel,
	input  wire logic [ppu_pkg::VEC_W-1:0]     acc,
	input  wire logic [ppu_pkg::LANE_W-1:0]    dt,
	output logic      [ppu_pkg::VEC_W-1:0]     pos_new,
	output logic      [ppu_pkg::VEC_W-1:0]     vel_new
);

	logic signed [32:0] pv_s1 [3];
	logic signed [32:0] va_s1 [3];
	logic [ppu_pkg::VEC_W-1:0] pos_s1;
	logic [ppu_pkg::VEC_W-1:0] vel_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos;
			vel_s1 <= vel;
			for (int k = 0; k < 3; k++) begin
				pv_s1[k] <= $signed(vel[16*k +: 16]) * $signed({1'b0, dt});
				va_s1[k] <= $signed(acc[16*k +: 16]) * $signed({1'b0, dt});
			end
		end
	end

	always_comb begin
		logic signed [25:0] sp;
		logic signed [25:0] sv;
		for (int k = 0; k < 3; k++) begin
			sp = 26'($signed(pos_s1[16*k +: 16])) + 26'(pv_s1[k] >>> 8);
			sv = 26'($signed(vel_s1[16*k +: 16])) + 26'(va_s1[k] >>> 8);
			pos_new[16*k +: 16] = ppu_pkg::sat16(sp);
			vel_new[16*k +: 16] = ppu_pkg::sat16(sv);
		end
	end

endmodule

`default_nettype wire

[rtl/ppu_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ppu_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ppu_pkg::div_req_t   req,
	output ppu_pkg::div_rsp_t        rsp
);

	localparam int unsigned N = ppu_pkg::ACC_W;

	logic                         busy_q;
	logic                         done_q;
	logic [4:0]                   cnt_q;
	logic [N-1:0]                 quo_q;
	logic [ppu_pkg::LANE_W-1:0]   rem_q;
	logic [ppu_pkg::LANE_W-1:0]   dvs_q;
	logic [ppu_pkg::LANE_W:0]     trial;
	logic                         fits;

	assign trial = {rem_q, quo_q[N-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? ppu_pkg::LANE_W'(trial - {1'b0, dvs_q})
			              : trial[ppu_pkg::LANE_W-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/particle_pool_update.sv]
`default_nettype none

// Channel | Signals                                   | Direction
// in      | in_valid/in_ready, req_type, delta_time   | request in
// out     | out_valid/out_ready, particle fields      | result out
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register write in
//
// Tick: each live entry is read, multiplied and written back; the read state
// then starts the divider, new particles are emitted, and each live particle is
// streamed out with one memory read per entry.
// Append, clear: the result is loaded into the output registers from ST_ONE.
// Reset clears counters and loads config defaults; no pool sweep.
// A stalled out_ready holds the walk at the output stage.
module particle_pool_update #(
	parameter int unsigned POOL_DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       req_type,
	input  wire logic [15:0]                      delta_time,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  particle_valid,
	output logic signed [15:0]                    pos_x,
	output logic signed [15:0]                    pos_y,
	output logic signed [15:0]                    pos_z,
	output logic [15:0]                           life_left,
	output logic [6:0]                            live_count,
	output logic                                  append_refused,
	output logic                                  is_last,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ppu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ppu_pkg::VEC_W-1:0]        cfg_data
);

	localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int unsigned CW = ppu_pkg::CNT_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_T_RD, ST_T_MUL, ST_T_WR, ST_DIV, ST_EMIT, ST_O_RD, ST_O_PUSH, ST_ONE
	} state_t;

	state_t state_q;

	logic [ppu_pkg::VEC_W-1:0]  emit_pos_q, init_vel_q, accel_q;
	logic [15:0]                lifetime_q, period_q;
	logic [CW-1:0]              max_live_q;

	logic [CW-1:0]              alive_q, r_q, w_q;
	logic [ppu_pkg::ACC_W-1:0]  accum_q, n_q, cnt_q;
	logic [15:0]                dt_q;
	logic                       keep_q, refused_q;

	logic [CW-1:0]              limit;
	logic                       room;
	logic                       can_push;
	logic                       load_out;
	ppu_pkg::entry_t            rdata, wdata, dflt;
	logic                       we, re;
	logic [AW-1:0]              waddr, raddr;
	logic [ppu_pkg::VEC_W-1:0]  pos_new, vel_new;
	ppu_pkg::div_req_t          div_req;
	ppu_pkg::div_rsp_t          div_rsp;

	assign limit    = (max_live_q < DEPTH_C) ? max_live_q : DEPTH_C;
	assign room     = alive_q < limit;
	assign can_push = !out_valid || out_ready;
	assign load_out = (state_q == ST_O_PUSH || state_q == ST_ONE) && can_push;
	assign in_ready = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;

	assign dflt = '{pos: emit_pos_q, vel: init_vel_q, acc: accel_q, life: lifetime_q};

	always_comb begin
		we    = 1'b0;
		waddr = alive_q[AW-1:0];
		wdata = dflt;
		re    = 1'b0;
		raddr = r_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				we = in_valid && req_type == ppu_pkg::REQ_APPEND && room;
			end
			ST_T_RD: begin
				re = r_q != alive_q;
			end
			ST_T_WR: begin
				we    = keep_q;
				waddr = w_q[AW-1:0];
				wdata = '{pos: pos_new, vel: vel_new, acc: rdata.acc,
				          life: rdata.life - dt_q};
			end
			ST_EMIT: begin
				we = cnt_q != n_q && room;
			end
			ST_O_RD: begin
				re = 1'b1;
			end
			default: ;
		endcase
	end

	assign div_req.start    = state_q == ST_T_RD && r_q == alive_q;
	assign div_req.dividend = ppu_pkg::ACC_W'(accum_q + {1'b0, dt_q});
	assign div_req.divisor  = (period_q == '0) ? 16'd1 : period_q;

	ppu_pool_mem #(.DEPTH(POOL_DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	ppu_integ u_integ (
		.clk     (clk),
		.en      (state_q == ST_T_MUL),
		.pos     (rdata.pos),
		.vel     (rdata.vel),
		.acc     (rdata.acc),
		.dt      (dt_q),
		.pos_new (pos_new),
		.vel_new (vel_new)
	);

	ppu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_pos_q <= '0;
			init_vel_q <= '0;
			accel_q    <= '0;
			lifetime_q <= 16'd256;
			period_q   <= 16'd256;
			max_live_q <= 7'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppu_pkg::CFG_EMIT_POS: emit_pos_q <= cfg_data;
				ppu_pkg::CFG_INIT_VEL: init_vel_q <= cfg_data;
				ppu_pkg::CFG_ACCEL:    accel_q    <= cfg_data;
				ppu_pkg::CFG_LIFETIME: lifetime_q <= cfg_data[15:0];
				ppu_pkg::CFG_PERIOD:   period_q   <= cfg_data[15:0];
				ppu_pkg::CFG_MAX_LIVE: max_live_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			alive_q        <= '0;
			accum_q        <= '0;
			r_q            <= '0;
			w_q            <= '0;
			n_q            <= '0;
			cnt_q          <= '0;
			dt_q           <= '0;
			keep_q         <= 1'b0;
			refused_q      <= 1'b0;
			out_valid      <= 1'b0;
			particle_valid <= 1'b0;
			pos_x          <= '0;
			pos_y          <= '0;
			pos_z          <= '0;
			life_left      <= '0;
			live_count     <= '0;
			append_refused <= 1'b0;
			is_last        <= 1'b0;
		end else begin
			if (load_out)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						dt_q      <= delta_time;
						refused_q <= req_type == ppu_pkg::REQ_APPEND && !room;
						r_q       <= '0;
						w_q       <= '0;
						case (req_type)
							ppu_pkg::REQ_TICK: begin
								state_q <= ST_T_RD;
							end
							ppu_pkg::REQ_APPEND: begin
								if (room)
									alive_q <= alive_q + 1'b1;
								state_q   <= ST_ONE;
							end
							ppu_pkg::REQ_CLEAR: begin
								alive_q <= '0;
								accum_q <= '0;
								state_q <= ST_ONE;
							end
							default: state_q <= ST_ONE;
						endcase
					end
				end
				ST_T_RD: begin
					if (r_q == alive_q) begin
						alive_q <= w_q;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_T_MUL;
					end
				end
				ST_T_MUL: begin
					keep_q  <= rdata.life > dt_q;
					state_q <= ST_T_WR;
				end
				ST_T_WR: begin
					if (keep_q)
						w_q <= w_q + 1'b1;
					r_q     <= r_q + 1'b1;
					state_q <= ST_T_RD;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						n_q     <= div_rsp.quo;
						accum_q <= ppu_pkg::ACC_W'(div_rsp.rem);
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cnt_q != n_q && room) begin
						alive_q <= alive_q + 1'b1;
						cnt_q   <= cnt_q + 1'b1;
					end else begin
						r_q     <= '0;
						state_q <= (alive_q == '0) ? ST_ONE : ST_O_RD;
					end
				end
				ST_O_RD: begin
					state_q <= ST_O_PUSH;
				end
				ST_O_PUSH: begin
					if (can_push) begin
						particle_valid <= 1'b1;
						pos_x          <= rdata.pos[15:0];
						pos_y          <= rdata.pos[31:16];
						pos_z          <= rdata.pos[47:32];
						life_left      <= rdata.life;
						live_count     <= alive_q;
						append_refused <= 1'b0;
						is_last        <= r_q + 1'b1 == alive_q;
						r_q            <= r_q + 1'b1;
						state_q        <= (r_q + 1'b1 == alive_q) ? ST_IDLE : ST_O_RD;
					end
				end
				ST_ONE: begin
					if (can_push) begin
						particle_valid <= 1'b0;
						pos_x          <= '0;
						pos_y          <= '0;
						pos_z          <= '0;
						life_left      <= '0;
						live_count     <= alive_q;
						append_refused <= refused_q;
						is_last        <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/ppu_checker.sv]
`default_nettype none

`include "particle_pool_update_defines.svh"

module ppu_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic                             particle_valid,
	input wire logic signed [15:0]               pos_x,
	input wire logic [15:0]                      life_left,
	input wire logic [6:0]                       live_count,
	input wire logic                             append_refused,
	input wire logic                             is_last
);

	`PPU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(is_last), "result dropped while stalled")
	`PPU_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
	`PPU_ASSERT_NOW(a_empty_result, out_valid && !particle_valid, is_last && pos_x == 16'sd0 && life_left == 16'd0, "empty result malformed")
	`PPU_ASSERT_NOW(a_particle_live, out_valid && particle_valid, live_count != 7'd0 && !append_refused, "particle result malformed")

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (.*);

`default_nettype wire

[test/tb_particle_pool_update.sv]
`default_nettype none

module tb_particle_pool_update;

	localparam int DEPTH = 64;
	localparam logic [ppu_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

	typedef struct {
		logic        pvalid;
		logic [15:0] px, py, pz;
		logic [15:0] life;
		logic [6:0]  cnt;
		logic        refused;
		logic        last;
	} particle_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [1:0] req_type;
	logic [15:0] delta_time;
	logic particle_valid, append_refused, is_last;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic [15:0] life_left;
	logic [6:0] live_count;
	logic [ppu_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ppu_pkg::VEC_W-1:0] cfg_data;

	particle_pool_update u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .delta_time(delta_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.particle_valid(particle_valid), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.life_left(life_left), .live_count(live_count),
		.append_refused(append_refused), .is_last(is_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the block
	logic [47:0] sh_emit, sh_vel0, sh_acc0;
	logic [15:0] sh_lifetime, sh_period;
	logic [6:0]  sh_max_live;
	logic [47:0] pp_pos [DEPTH];
	logic [47:0] pp_vel [DEPTH];
	logic [47:0] pp_acc [DEPTH];
	logic [15:0] pp_life [DEPTH];
	int unsigned pp_count;
	logic [16:0] pp_accum;

	particle_t particle_q[$];
	int errors = 0;
	int burst_left = 0;
	int hold_cycles = 0;
	bit stall_mode = 0;

	function automatic logic [47:0] euler_step(logic [47:0] a, logic [47:0] b,
			logic [15:0] dt);
		logic [47:0] r;
		longint p, s;
		r = a;
		for (int k = 0; k < 3; k++) begin
			p = longint'($signed(b[k*16 +: 16])) * longint'({1'b0, dt});
			p = p >>> 8;
			s = longint'($signed(a[k*16 +: 16])) + p;
			if (s > 32767)
				s = 32767;
			else if (s < -32768)
				s = -32768;
			r[k*16 +: 16] = s[15:0];
		end
		return r;
	endfunction

	function automatic bit add_default();
		int unsigned lim;
		lim = (sh_max_live < DEPTH) ? sh_max_live : DEPTH;
		if (pp_count >= lim)
			return 0;
		pp_pos[pp_count] = sh_emit;
		pp_vel[pp_count] = sh_vel0;
		pp_acc[pp_count] = sh_acc0;
		pp_life[pp_count] = sh_lifetime;
		pp_count++;
		return 1;
	endfunction

	task automatic push_result(logic v, logic [47:0] pos, logic [15:0] life,
			logic refused, logic last);
		particle_t e;
		e.pvalid = v;
		e.px = pos[15:0];
		e.py = pos[31:16];
		e.pz = pos[47:32];
		e.life = life;
		e.cnt = pp_count[6:0];
		e.refused = refused;
		e.last = last;
		particle_q = {particle_q, e};
	endtask

	task automatic predict_request(logic [1:0] r, logic [15:0] dt);
		int unsigned w, n, per;
		int lf;
		logic [16:0] acc;
		bit ok;
		w = 0;
		case (r)
			ppu_pkg::REQ_TICK: begin
				for (int unsigned i = 0; i < pp_count; i++) begin
					lf = int'(pp_life[i]) - int'(dt);
					if (lf > 0) begin
						pp_pos[w] = euler_step(pp_pos[i], pp_vel[i], dt);
						pp_vel[w] = euler_step(pp_vel[i], pp_acc[i], dt);
						pp_acc[w] = pp_acc[i];
						pp_life[w] = lf[15:0];
						w++;
					end
				end
				pp_count = w;
				per = (sh_period == 0) ? 1 : sh_period;
				acc = pp_accum + dt;
				n = acc / per;
				pp_accum = 17'(acc % per);
				for (int unsigned i = 0; i < n; i++)
					if (!add_default())
						break;
				if (pp_count == 0)
					push_result(0, '0, '0, 0, 1);
				else
					for (int unsigned i = 0; i < pp_count; i++)
						push_result(1, pp_pos[i], pp_life[i], 0, i + 1 == pp_count);
			end
			ppu_pkg::REQ_APPEND: begin
				ok = add_default();
				push_result(0, '0, '0, !ok, 1);
			end
			ppu_pkg::REQ_CLEAR: begin
				pp_count = 0;
				pp_accum = '0;
				push_result(0, '0, '0, 0, 1);
			end
			default: push_result(0, '0, '0, 0, 1);
		endcase
	endtask

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		particle_t e;
		if (arst_n && out_valid && out_ready) begin
			if (particle_q.size() == 0) begin
				report("unexpected transfer", 1, 0);
			end else begin
				e = particle_q.pop_front();
				if (particle_valid !== e.pvalid)
					report("particle_valid", int'(particle_valid), int'(e.pvalid));
				if (pos_x !== e.px) report("pos_x", int'(pos_x), int'(e.px));
				if (pos_y !== e.py) report("pos_y", int'(pos_y), int'(e.py));
				if (pos_z !== e.pz) report("pos_z", int'(pos_z), int'(e.pz));
				if (life_left !== e.life) report("life_left", int'(life_left), int'(e.life));
				if (live_count !== e.cnt) report("live_count", int'(live_count), int'(e.cnt));
				if (append_refused !== e.refused)
					report("append_refused", int'(append_refused), int'(e.refused));
				if (is_last !== e.last) report("is_last", int'(is_last), int'(e.last));
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= ~stall_mode;
			out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	task automatic send_req(logic [1:0] r, logic [15:0] dt);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= r;
		delta_time <= dt;
		do @(posedge clk); while (!in_ready);
		predict_request(r, dt);
		burst_left--;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (particle_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [ppu_pkg::CFG_IDX_W-1:0] idx, logic [47:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			ppu_pkg::CFG_EMIT_POS: sh_emit = d;
			ppu_pkg::CFG_INIT_VEL: sh_vel0 = d;
			ppu_pkg::CFG_ACCEL:    sh_acc0 = d;
			ppu_pkg::CFG_LIFETIME: sh_lifetime = d[15:0];
			ppu_pkg::CFG_PERIOD:   sh_period = d[15:0];
			ppu_pkg::CFG_MAX_LIVE: sh_max_live = d[6:0];
			default: ;
		endcase
	endtask

	task automatic test_defaults();
		send_req(ppu_pkg::REQ_TICK, 16'd0);
		send_req(ppu_pkg::REQ_APPEND, 16'd0);
		send_req(ppu_pkg::REQ_TICK, 16'd128);
		send_req(ppu_pkg::REQ_TICK, 16'd256);
		send_req(ppu_pkg::REQ_NONE, 16'hFFFF);
		send_req(ppu_pkg::REQ_CLEAR, 16'd0);
		wait_idle();
	endtask

	task automatic test_full_pool();
		write_reg(ppu_pkg::CFG_MAX_LIVE, 48'd2);
		write_reg(ppu_pkg::CFG_LIFETIME, 48'hFFFF);
		write_reg(ppu_pkg::CFG_PERIOD, 48'hFFFF);
		repeat (3) send_req(ppu_pkg::REQ_APPEND, 16'd0);
		wait_idle();
		write_reg(ppu_pkg::CFG_MAX_LIVE, 48'd0);
		send_req(ppu_pkg::REQ_APPEND, 16'd0);
		send_req(ppu_pkg::REQ_TICK, 16'd1);
		wait_idle();
		write_reg(ppu_pkg::CFG_MAX_LIVE, 48'd1);
		send_req(ppu_pkg::REQ_TICK, 16'd1);
		send_req(ppu_pkg::REQ_CLEAR, 16'd0);
		wait_idle();
	endtask

	task automatic test_emission();
		write_reg(ppu_pkg::CFG_MAX_LIVE, 48'd100);
		write_reg(ppu_pkg::CFG_PERIOD, 48'd0);
		write_reg(ppu_pkg::CFG_LIFETIME, 48'd4000);
		send_req(ppu_pkg::REQ_TICK, 16'd70);
		wait_idle();
		write_reg(ppu_pkg::CFG_PERIOD, 48'd1);
		send_req(ppu_pkg::REQ_TICK, 16'hFFFF);
		send_req(ppu_pkg::REQ_APPEND, 16'd0);
		send_req(ppu_pkg::REQ_CLEAR, 16'd0);
		wait_idle();
		write_reg(ppu_pkg::CFG_PERIOD, 48'd300);
		send_req(ppu_pkg::REQ_TICK, 16'd1000);
		send_req(ppu_pkg::REQ_TICK, 16'd299);
		wait_idle();
	endtask

	task automatic test_saturation();
		write_reg(ppu_pkg::CFG_EMIT_POS, 48'h7FFF_8000_0000);
		write_reg(ppu_pkg::CFG_INIT_VEL, 48'h8000_7FFF_FFFF);
		write_reg(ppu_pkg::CFG_ACCEL, 48'h7FFF_8000_0001);
		write_reg(ppu_pkg::CFG_LIFETIME, 48'hFFFF);
		write_reg(ppu_pkg::CFG_PERIOD, 48'hFFFF);
		write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
		send_req(ppu_pkg::REQ_CLEAR, 16'd0);
		send_req(ppu_pkg::REQ_APPEND, 16'd0);
		send_req(ppu_pkg::REQ_TICK, 16'd1);
		send_req(ppu_pkg::REQ_TICK, 16'hFFFE);
		wait_idle();
		write_reg(ppu_pkg::CFG_LIFETIME, 48'd0);
		send_req(ppu_pkg::REQ_APPEND, 16'd0);
		send_req(ppu_pkg::REQ_TICK, 16'd0);
		wait_idle();
		write_reg(ppu_pkg::CFG_MAX_LIVE, 48'd64);
	endtask

	task automatic test_backpressure();
		write_reg(ppu_pkg::CFG_LIFETIME, 48'hFFFF);
		write_reg(ppu_pkg::CFG_PERIOD, 48'd1);
		write_reg(ppu_pkg::CFG_MAX_LIVE, 48'd64);
		@(negedge clk);
		hold_cycles = 800;
		@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_req(ppu_pkg::REQ_TICK, 16'($urandom_range(0, 3)));
		wait_idle();
		write_reg(ppu_pkg::CFG_MAX_LIVE, 48'd3);
		send_req(ppu_pkg::REQ_TICK, 16'd1);
		send_req(ppu_pkg::REQ_APPEND, 16'd0);
		send_req(ppu_pkg::REQ_CLEAR, 16'd0);
		wait_idle();
	endtask

	task automatic test_random();
		logic [1:0] r;
		logic [15:0] dt;
		int k;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(ppu_pkg::CFG_EMIT_POS, 48'({$urandom, $urandom}));
			write_reg(ppu_pkg::CFG_INIT_VEL, 48'({$urandom, $urandom}) & {3{16'h81FF}});
			write_reg(ppu_pkg::CFG_ACCEL, 48'({$urandom, $urandom}));
			write_reg(ppu_pkg::CFG_LIFETIME,
				(ph == 0) ? 48'hFFFF : 48'($urandom_range(1, 4000)));
			write_reg(ppu_pkg::CFG_PERIOD,
				(ph == 1) ? 48'hFFFF : 48'($urandom_range(1, 600)));
			write_reg(ppu_pkg::CFG_MAX_LIVE,
				(ph == 2) ? 48'd127 : 48'($urandom_range(0, 64)));
			for (int i = 0; i < 35; i++) begin
				k = $urandom_range(0, 19);
				r = (k < 12) ? ppu_pkg::REQ_TICK : (k < 17) ? ppu_pkg::REQ_APPEND :
					(k < 18) ? ppu_pkg::REQ_CLEAR : ppu_pkg::REQ_NONE;
				dt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
				send_req(r, dt);
			end
			wait_idle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = ppu_pkg::REQ_TICK;
		delta_time = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		out_ready = 1'b0;
		sh_emit = '0;
		sh_vel0 = '0;
		sh_acc0 = '0;
		sh_lifetime = 16'd256;
		sh_period = 16'd256;
		sh_max_live = 7'd64;
		pp_count = 0;
		pp_accum = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_full_pool();
		test_emission();
		test_saturation();
		test_backpressure();
		test_random();
		wait_idle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#80000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/ppu_pkg.sv
rtl/ppu_pool_mem.sv
rtl/ppu_integ.sv
rtl/ppu_div.sv
rtl/particle_pool_update.sv
rtl/ppu_checker.sv
test/tb_particle_pool_update.sv
